@@ rtl/core/pwsd_pkg.sv @@
// ----------------------------------------------------------------------------
// pwsd_pkg
// Shared types and constants of the multi-priority work-stealing deque.
// ----------------------------------------------------------------------------
`default_nettype none

package pwsd_pkg;

  // Port field widths
  localparam int FUNC_W       = 2;
  localparam int PRIO_W       = 2;
  localparam int HANDLE_PORT_W = 32;
  localparam int STATUS_W     = 2;

  // Defaults of the top-level parameters
  localparam int DEPTH_DEF        = 512;
  localparam int PRIORITIES_DEF   = 4;
  localparam int HANDLE_WIDTH_DEF = 32;

  // Command queue between front and back
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  // Function codes on func_i
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STEAL  = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_POP,
    OP_STEAL,
    OP_NONE
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e                      op;
    logic [PRIO_W-1:0]        level;
    logic [HANDLE_PORT_W-1:0] handle;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/pwsd_front.sv @@
// ----------------------------------------------------------------------------
// pwsd_front
// Accepts commands, decodes the function code and clamps the insert level.
// ----------------------------------------------------------------------------
`default_nettype none

module pwsd_front import pwsd_pkg::*; #(
  parameter int PRIORITIES = PRIORITIES_DEF
) (
  input  wire logic                     start_i,
  input  wire logic                     full_i,
  input  wire logic [FUNC_W-1:0]        func_i,
  input  wire logic [PRIO_W-1:0]        prio_i,
  input  wire logic [HANDLE_PORT_W-1:0] task_handle_i,
  output logic                          push_o,
  output cmd_t                          cmd_o
);

  assign push_o = start_i && !full_i;

  always_comb begin
    cmd_o.handle = task_handle_i;
    unique case (func_i)
      FUNC_INSERT: cmd_o.op = OP_INSERT;
      FUNC_POP:    cmd_o.op = OP_POP;
      FUNC_STEAL:  cmd_o.op = OP_STEAL;
      default:     cmd_o.op = OP_NONE;
    endcase
    // clamp levels beyond the last deque
    if (int'(prio_i) >= PRIORITIES) begin
      cmd_o.level = PRIO_W'(PRIORITIES - 1);
    end else begin
      cmd_o.level = prio_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pwsd_cmdq.sv @@
// ----------------------------------------------------------------------------
// pwsd_cmdq
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pwsd_cmdq import pwsd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output cmd_t      cmd_o
);

  cmd_t                  entries_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pwsd_back.sv @@
// ----------------------------------------------------------------------------
// pwsd_back
// Executes queued commands: per-level head/tail pointers and the task store.
// ----------------------------------------------------------------------------
`default_nettype none

module pwsd_back import pwsd_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int PRIORITIES   = PRIORITIES_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cmd_valid_i,
  input  wire cmd_t                     cmd_i,
  output logic                          cmd_pop_o,
  output logic                          done_o,
  output status_e                       status_o,
  output logic [PRIO_W-1:0]             served_prio_o,
  output logic [HANDLE_PORT_W-1:0]      out_handle_o
);

  localparam int PTR_MOD = 2 * DEPTH;
  localparam int PTR_W   = $clog2(PTR_MOD);
  localparam int LVL_W   = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
  localparam int ENTRIES = PRIORITIES * DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);

  logic [PTR_W-1:0]        head_q [PRIORITIES];
  logic [PTR_W-1:0]        head_d [PRIORITIES];
  logic [PTR_W-1:0]        tail_q [PRIORITIES];
  logic [PTR_W-1:0]        tail_d [PRIORITIES];
  logic [HANDLE_WIDTH-1:0] task_store_q [ENTRIES];
  logic [HANDLE_WIDTH-1:0] rd_data_q;

  logic [PRIORITIES-1:0]   nonempty;
  logic                    found;
  logic [LVL_W-1:0]        sel_lvl;
  logic [LVL_W-1:0]        ins_lvl;
  logic [PTR_W-1:0]        ins_head, ins_tail, ins_occ;
  logic                    ins_full;
  logic [PTR_W-1:0]        pop_head_dec, rd_ptr;
  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  logic [HANDLE_WIDTH-1:0] wr_data;

  logic                    done_q, done_d;
  status_e                 status_q, status_d;
  logic [PRIO_W-1:0]       served_q, served_d;
  logic                    from_mem_q, from_mem_d;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(PTR_MOD - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] ptr);
    return (ptr == '0) ? PTR_W'(PTR_MOD - 1) : ptr - PTR_W'(1);
  endfunction

  // Store address of a pointer in a level: level * DEPTH + (ptr mod DEPTH)
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] slot;
    slot = (ptr >= PTR_W'(DEPTH)) ? ptr - PTR_W'(DEPTH) : ptr;
    return ADDR_W'(int'(lvl) * DEPTH + int'(slot));
  endfunction

  assign cmd_pop_o = cmd_valid_i;

  always_comb begin
    nonempty = '0;
    found    = 1'b0;
    sel_lvl  = '0;
    for (int p = 0; p < PRIORITIES; p++) begin
      nonempty[p] = (head_q[p] != tail_q[p]);
    end
    // lowest-numbered non-empty level wins
    for (int p = PRIORITIES - 1; p >= 0; p--) begin
      if (nonempty[p]) begin
        found   = 1'b1;
        sel_lvl = LVL_W'(p);
      end
    end
  end

  always_comb begin
    ins_lvl  = LVL_W'(cmd_i.level);
    ins_head = head_q[ins_lvl];
    ins_tail = tail_q[ins_lvl];
    ins_occ  = (ins_head >= ins_tail) ? ins_head - ins_tail
                                      : PTR_W'(int'(ins_head) + PTR_MOD - int'(ins_tail));
    ins_full = (ins_occ >= PTR_W'(DEPTH));
    pop_head_dec = ptr_dec(head_q[sel_lvl]);
    rd_ptr   = (cmd_i.op == OP_POP) ? pop_head_dec : tail_q[sel_lvl];
    wr_addr  = slot_addr(ins_lvl, ins_head);
    rd_addr  = slot_addr(sel_lvl, rd_ptr);
    wr_data  = HANDLE_WIDTH'(cmd_i.handle);
  end

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    done_d     = 1'b0;
    status_d   = ST_OK;
    served_d   = '0;
    from_mem_d = 1'b0;
    if (cmd_valid_i) begin
      done_d = 1'b1;
      unique case (cmd_i.op) inside
        OP_INSERT: begin
          served_d = cmd_i.level;
          if (ins_full) begin
            status_d = ST_FULL;
          end else begin
            mem_we          = 1'b1;
            head_d[ins_lvl] = ptr_inc(ins_head);
          end
        end
        OP_POP, OP_STEAL: begin
          if (!found) begin
            status_d = ST_EMPTY;
          end else begin
            served_d   = PRIO_W'(sel_lvl);
            mem_re     = 1'b1;
            from_mem_d = 1'b1;
            if (cmd_i.op == OP_POP) begin
              head_d[sel_lvl] = pop_head_dec;
            end else begin
              tail_d[sel_lvl] = ptr_inc(tail_q[sel_lvl]);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PRIORITIES; p++) begin
        head_q[p] <= '0;
        tail_q[p] <= '0;
      end
      done_q     <= 1'b0;
      status_q   <= ST_OK;
      served_q   <= '0;
      from_mem_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      done_q     <= done_d;
      status_q   <= status_d;
      served_q   <= served_d;
      from_mem_q <= from_mem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      task_store_q[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= task_store_q[rd_addr];
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign served_prio_o = served_q;
  assign out_handle_o  = from_mem_q ? HANDLE_PORT_W'(rd_data_q) : '0;

endmodule

`default_nettype wire

@@ rtl/core/priority_work_stealing_deque_core.sv @@
// ----------------------------------------------------------------------------
// priority_work_stealing_deque_core
// Task deques, one per priority level, with owner pop and steal.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive func_i, prio_i and task_handle_i with start_i high;
//   the word is taken at a rising edge where busy_o is low. Insert pushes at
//   the head of the deque of level prio_i, owner pop takes the newest word of
//   the lowest-numbered non-empty level, steal takes its oldest word.
//   Result channel: each command gives exactly one result, shown for one
//   cycle with done_o high; status_o, served_prio_o and out_handle_o are
//   valid only in that cycle. The receiver cannot stall.
//   Timing: an accepted word is written into the command queue, executed by
//   the back end, and its result is registered before done_o rises.
//   Throughput: one command per cycle while busy_o is low, set by the back end,
//   which reads or writes the task store through one write and one read port each cycle.
//   A two-entry command queue sits between decode and execution; busy_o is
//   high only while it is full.
//   Reset: all deques are empty, the command queue is flushed and no result
//   is pending. The task store is not cleared; only written slots are read.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_work_stealing_deque_core import pwsd_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int PRIORITIES   = PRIORITIES_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [FUNC_W-1:0]        func_i,
  input  wire logic [PRIO_W-1:0]        prio_i,
  input  wire logic [HANDLE_PORT_W-1:0] task_handle_i,
  output logic                          done_o,
  output logic [STATUS_W-1:0]           status_o,
  output logic [PRIO_W-1:0]             served_prio_o,
  output logic [HANDLE_PORT_W-1:0]      out_handle_o
);

  logic    q_full, q_valid, q_pop, push;
  cmd_t    front_cmd, back_cmd;
  status_e status;

  pwsd_front #(
    .PRIORITIES (PRIORITIES)
  ) u_front (
    .start_i       (start_i),
    .full_i        (q_full),
    .func_i        (func_i),
    .prio_i        (prio_i),
    .task_handle_i (task_handle_i),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  pwsd_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (back_cmd)
  );

  pwsd_back #(
    .DEPTH        (DEPTH),
    .PRIORITIES   (PRIORITIES),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (back_cmd),
    .cmd_pop_o     (q_pop),
    .done_o        (done_o),
    .status_o      (status),
    .served_prio_o (served_prio_o),
    .out_handle_o  (out_handle_o)
  );

  assign busy_o   = q_full;
  assign status_o = status;

endmodule

`default_nettype wire

@@ rtl/core/pwsd_checker.sv @@
// ----------------------------------------------------------------------------
// pwsd_checker
// Port-level checks of the deque core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pwsd_checker import pwsd_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     start_i,
  input wire logic                     busy_o,
  input wire logic [FUNC_W-1:0]        func_i,
  input wire logic                     done_o,
  input wire logic [STATUS_W-1:0]      status_o,
  input wire logic [PRIO_W-1:0]        served_prio_o,
  input wire logic [HANDLE_PORT_W-1:0] out_handle_o
);

  // every accepted word gives a result after the command queue and the result registers
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("accepted command produced no result");

  // no result without an earlier accepted command
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without an accepted command");

  // an empty pop or steal reports level zero and a zero handle
  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (served_prio_o == '0 && out_handle_o == '0))
    else $error("empty result carries data");

  // an insert never returns a handle and never reports empty
  a_insert_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start_i && !busy_o && func_i == FUNC_INSERT, 2))
      |-> (out_handle_o == '0 && status_o != ST_EMPTY))
    else $error("bad insert result");

endmodule

bind priority_work_stealing_deque_core pwsd_checker u_pwsd_checker (.*);

`default_nettype wire
